// ===== hdl/tsre_pkg.sv =====
// shared types, constants and helpers for the threshold sparse run encoder
package tsre_pkg;

  localparam int WORD_BITS         = 32;
  localparam int INDEX_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH       = 4;

  // record kind carried on the result channel tuser
  typedef enum logic [1:0] {
    KIND_VALUE  = 2'd0,
    KIND_LENGTH = 2'd1,
    KIND_START  = 2'd2,
    KIND_TOTAL  = 2'd3
  } kind_t;

  // one classified voxel, expands into one to four records
  typedef struct packed {
    logic                 has_value;
    logic                 has_close;
    logic                 has_total;
    logic [WORD_BITS-1:0] value;
    logic [WORD_BITS-1:0] run_len;
    logic [WORD_BITS-1:0] run_start;
    logic [WORD_BITS-1:0] total;
  } cmd_t;

  localparam int CMD_BITS = $bits(cmd_t);

  function automatic logic [WORD_BITS-1:0] sat_inc(input logic [WORD_BITS-1:0] v);
    sat_inc = (v == {WORD_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ===== hdl/threshold_sparse_run_encoder_unit.sv =====
// top level of the threshold sparse run encoder
//
//  channel | direction | tdata / data      | tuser        | tlast
//  --------+-----------+-------------------+--------------+--------------
//  in_     | slave     | voxel_value[31:0] | -            | final_voxel
//  out_    | master    | record_word[31:0] | record_kind  | last_of_item
//  cfg_    | slave     | threshold[31:0]   | -            | -
//
// one voxel beat is taken per cycle; records leave one per cycle, while out_tready is high, from a registered output
// a voxel yields zero to four records, so bursts are held in a four-entry command queue
// and in_tready drops only while that queue is full
// a voxel's first record passes through the command queue, then the registered output stage
// reset is synchronous, active low, and clears run state, the queue and the output stage
// the threshold register is taken in any cycle (cfg_ready is always high)
module threshold_sparse_run_encoder_unit import tsre_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  // voxel stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] voxel_value
  input  logic        in_tlast,   // final_voxel
  // record stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] record_word
  output logic [1:0]  out_tuser,  // [1:0] record_kind
  output logic        out_tlast,  // last_of_item
  // threshold write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data    // [31:0] threshold
);

  logic [WORD_BITS-1:0] threshold_r;

  logic  push;
  cmd_t  push_cmd;
  cmd_t  head_cmd;
  logic  pop;
  logic  queue_empty;
  logic  queue_full;
  kind_t out_kind;

  // threshold register, signed compare happens in the front end
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      threshold_r <= cfg_data;
    end
  end

  // front end: classify each voxel beat and track run, index and total
  tsre_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .threshold  (threshold_r),
    .in_valid   (in_tvalid),
    .in_value   (in_tdata),
    .in_final   (in_tlast),
    .queue_full (queue_full),
    .in_ready   (in_tready),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // command queue decouples voxel intake from record output
  tsre_queue #(
    .WIDTH (CMD_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .head_data (head_cmd),
    .empty     (queue_empty),
    .full      (queue_full)
  );

  // back end: one record per cycle, while the output is not stalled, into the output register
  tsre_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_cmd    (head_cmd),
    .queue_empty (queue_empty),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (out_kind),
    .out_word    (out_tdata),
    .out_last    (out_tlast)
  );

  assign out_tuser = out_kind;

endmodule

// ===== hdl/tsre_front.sv =====
// front end: threshold compare, run and count tracking, command generation
module tsre_front import tsre_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [WORD_BITS-1:0] threshold,
  input  logic                 in_valid,
  input  logic [WORD_BITS-1:0] in_value,
  input  logic                 in_final,
  input  logic                 queue_full,
  output logic                 in_ready,
  output logic                 push,
  output cmd_t                 push_cmd
);

  logic [INDEX_BITS-1:0] voxel_index_r, voxel_index_nxt;
  logic [WORD_BITS-1:0]  run_length_r, run_length_nxt;
  logic [INDEX_BITS-1:0] run_start_r, run_start_nxt;
  logic [WORD_BITS-1:0]  selected_total_r, selected_total_nxt;

  logic                  accept;
  logic                  selected;
  logic                  run_open;
  logic                  close_now;
  logic [WORD_BITS-1:0]  len_after;
  logic [INDEX_BITS-1:0] start_after;
  logic [WORD_BITS-1:0]  total_after;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  assign selected    = $signed(in_value) > $signed(threshold);
  assign run_open    = (run_length_r != '0);
  assign close_now   = !selected && run_open;
  assign len_after   = selected ? sat_inc(run_length_r) : run_length_r;
  assign start_after = (selected && !run_open) ? voxel_index_r : run_start_r;
  assign total_after = selected ? sat_inc(selected_total_r) : selected_total_r;

  // a voxel that neither selects, closes nor ends the volume leaves no command
  assign push = accept && (selected || close_now || in_final);

  always_comb begin
    push_cmd.has_value = selected;
    push_cmd.has_close = close_now || (in_final && selected);
    push_cmd.has_total = in_final;
    push_cmd.value     = in_value;
    push_cmd.run_len   = len_after;
    push_cmd.run_start = WORD_BITS'(start_after);
    push_cmd.total     = total_after;
  end

  always_comb begin
    voxel_index_nxt    = voxel_index_r;
    run_length_nxt     = run_length_r;
    run_start_nxt      = run_start_r;
    selected_total_nxt = selected_total_r;
    if (accept) begin
      if (in_final) begin
        voxel_index_nxt    = '0;
        run_length_nxt     = '0;
        run_start_nxt      = '0;
        selected_total_nxt = '0;
      end else begin
        voxel_index_nxt    = voxel_index_r + 1'b1;
        run_length_nxt     = selected ? len_after : '0;
        run_start_nxt      = start_after;
        selected_total_nxt = total_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voxel_index_r    <= '0;
      run_length_r     <= '0;
      run_start_r      <= '0;
      selected_total_r <= '0;
    end else begin
      voxel_index_r    <= voxel_index_nxt;
      run_length_r     <= run_length_nxt;
      run_start_r      <= run_start_nxt;
      selected_total_r <= selected_total_nxt;
    end
  end

endmodule

// ===== hdl/tsre_queue.sv =====
// small register queue between front and back end
module tsre_queue import tsre_pkg::*; #(
  parameter int WIDTH = CMD_BITS,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty,
  output logic             full
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push;
  logic                do_pop;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_BITS'(DEPTH));
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/tsre_back.sv =====
// back end: expands queued commands into records on a registered output
module tsre_back import tsre_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 head_cmd,
  input  logic                 queue_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output kind_t                out_kind,
  output logic [WORD_BITS-1:0] out_word,
  output logic                 out_last
);

  logic                 out_valid_r, out_valid_nxt;
  kind_t                out_kind_r, out_kind_nxt;
  logic [WORD_BITS-1:0] out_word_r, out_word_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [3:0]           emitted_r, emitted_nxt;

  logic                 load_en;
  logic                 emit;
  logic [3:0]           mask;
  logic [3:0]           remain;
  logic [3:0]           pick;
  logic                 is_last;
  kind_t                pick_kind;
  logic [WORD_BITS-1:0] pick_word;

  // bit order follows record order: value, length, start, total
  assign mask    = {head_cmd.has_total, head_cmd.has_close, head_cmd.has_close,
                    head_cmd.has_value};
  assign remain  = mask & ~emitted_r;
  assign pick    = remain & (~remain + 4'd1);
  assign is_last = ((remain & ~pick) == 4'd0);

  assign load_en = !out_valid_r || out_ready;
  assign emit    = load_en && !queue_empty;
  assign pop     = emit && is_last;

  always_comb begin
    case (pick)
      4'b0001: begin
        pick_kind = KIND_VALUE;
        pick_word = head_cmd.value;
      end
      4'b0010: begin
        pick_kind = KIND_LENGTH;
        pick_word = head_cmd.run_len;
      end
      4'b0100: begin
        pick_kind = KIND_START;
        pick_word = head_cmd.run_start;
      end
      default: begin
        pick_kind = KIND_TOTAL;
        pick_word = head_cmd.total;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    emitted_nxt   = emitted_r;
    if (load_en) begin
      out_valid_nxt = emit;
    end
    if (emit) begin
      out_kind_nxt = pick_kind;
      out_word_nxt = pick_word;
      out_last_nxt = is_last;
      emitted_nxt  = is_last ? 4'd0 : (emitted_r | pick);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      emitted_r   <= 4'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      emitted_r   <= emitted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

endmodule

// ===== hdl/tsre_checker.sv =====
// port-level checks for the threshold sparse run encoder, bound to the top level
module tsre_checker import tsre_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // stalled record beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("record beat changed while stalled");

  // run length is always followed directly by its first index
  a_len_then_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == KIND_LENGTH |=>
      out_tvalid && out_tuser == KIND_START)
    else $error("run length not followed by run start");

  // a run length never ends the records of a voxel
  a_len_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_LENGTH |-> !out_tlast)
    else $error("run length marked last");

  // the total count always ends the records of a voxel
  a_total_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_TOTAL |-> out_tlast)
    else $error("total count not marked last");

endmodule

bind threshold_sparse_run_encoder_unit tsre_checker u_tsre_checker (.*);

// ===== tb/tb_threshold_sparse_run_encoder_unit.sv =====
// self-checking bench: voxel volumes in, encoded records checked against an in-bench encoder
module tb_threshold_sparse_run_encoder_unit;
  import tsre_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 12;
  localparam int HOLD_TICKS   = 60;
  localparam int ERROR_PRINTS = 40;

  typedef struct packed {
    logic [31:0] value;
    logic        final_mark;
  } voxel_beat_t;

  typedef struct {
    kind_t       kind;
    logic [31:0] word;
    logic        last;
  } record_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // encoder state mirrored in the bench
  logic [31:0]                   threshold_reg = '0;
  logic [INDEX_BITS_DEFAULT-1:0] voxel_idx = '0;
  logic [31:0]                   run_len = '0;
  logic [31:0]                   run_first = '0;
  logic [31:0]                   selected_cnt = '0;

  voxel_beat_t voxel_queue[$];
  record_t     due_records[$];
  int          voxels_queued = 0;
  int          voxels_taken = 0;
  int          errors = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  threshold_sparse_run_encoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic add_record(input kind_t kind, input logic [31:0] word);
    record_t rec;
    rec.kind = kind;
    rec.word = word;
    rec.last = 1'b0;
    due_records.push_back(rec);
  endtask

  // expected records for one accepted voxel, state updated as the block does
  task automatic encode_voxel(input logic [31:0] value, input logic final_mark);
    int first;
    first = due_records.size();
    if ($signed(value) > $signed(threshold_reg)) begin
      add_record(KIND_VALUE, value);
      if (run_len == 0) run_first = 32'(voxel_idx);
      if (run_len != '1) run_len = run_len + 1;
      if (selected_cnt != '1) selected_cnt = selected_cnt + 1;
    end else if (run_len != 0) begin
      add_record(KIND_LENGTH, run_len);
      add_record(KIND_START, run_first);
      run_len = '0;
    end
    voxel_idx = voxel_idx + 1'b1;
    if (final_mark) begin
      // volume end: flush an open run, then the count, then back to a fresh volume
      if (run_len != 0) begin
        add_record(KIND_LENGTH, run_len);
        add_record(KIND_START, run_first);
      end
      add_record(KIND_TOTAL, selected_cnt);
      voxel_idx = '0;
      run_len = '0;
      run_first = '0;
      selected_cnt = '0;
    end
    if (due_records.size() > first) due_records[due_records.size() - 1].last = 1'b1;
  endtask

  // voxel driver: a beat stays up until taken
  always @(posedge clk) begin : voxel_driver
    voxel_beat_t beat;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
      voxel_idx = '0;
      run_len = '0;
      run_first = '0;
      selected_cnt = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        encode_voxel(in_tdata, in_tlast);
        voxels_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (voxel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat = voxel_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= beat.value;
          in_tlast <= beat.final_mark;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started on request
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_left <= HOLD_TICKS;
      hold_served <= hold_requests;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // record checker
  always @(posedge clk) begin : record_check
    record_t rec;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_records.size() == 0) begin
        errors++;
        if (errors <= ERROR_PRINTS)
          $display("%0t unexpected record: expected none, actual kind %0d word %h last %b",
                   $time, out_tuser, out_tdata, out_tlast);
      end else begin
        rec = due_records.pop_front();
        if (kind_t'(out_tuser) != rec.kind) begin
          errors++;
          if (errors <= ERROR_PRINTS)
            $display("%0t record_kind: expected %0d actual %0d", $time, rec.kind, out_tuser);
        end
        if (out_tdata != rec.word) begin
          errors++;
          if (errors <= ERROR_PRINTS)
            $display("%0t record_word: expected %h actual %h", $time, rec.word, out_tdata);
        end
        if (out_tlast != rec.last) begin
          errors++;
          if (errors <= ERROR_PRINTS)
            $display("%0t last_of_item: expected %b actual %b", $time, rec.last, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("threshold_sparse_run_encoder_unit verification failed");
      $finish;
    end
  end

  task automatic push_voxel(input logic [31:0] value, input logic final_mark);
    voxel_beat_t beat;
    beat.value = value;
    beat.final_mark = final_mark;
    voxel_queue.push_back(beat);
    voxels_queued++;
  endtask

  // half the values near the threshold so runs open and close often
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5) return threshold_reg + 32'($urandom_range(5)) - 32'd2;
    else if (r < 8) return $urandom;
    else if (r == 8) return 32'h7fff_ffff;
    else return 32'h8000_0000;
  endfunction

  task automatic queue_random(input int count);
    int left;
    int len;
    int k;
    left = count;
    while (left > 0) begin
      if ($urandom_range(99) < 85) begin
        // whole volume ending with its final voxel
        len = ($urandom_range(19) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        for (k = 0; k < len; k++) push_voxel(pick_value(), k == len - 1);
        left -= len;
      end else begin
        push_voxel(pick_value(), $urandom_range(3) == 0);
        left--;
      end
    end
  endtask

  // all voxels taken, all records back, then a settling wait for voxels that emit nothing
  task automatic settle();
    while (voxels_taken != voxels_queued || due_records.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    threshold_reg = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [31:0] thr, input int send_pct, input int recv_pct,
                           input int count, input bit hold);
    settle();
    write_threshold(thr);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (hold) hold_requests++;
    queue_random(count);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset threshold of zero: equal value, extremes, run closes, final cases
    push_voxel(32'h0000_0000, 1'b0);
    push_voxel(32'h0000_0001, 1'b0);
    push_voxel(32'h7fff_ffff, 1'b0);
    push_voxel(32'h8000_0000, 1'b0);
    push_voxel(32'hffff_ffff, 1'b0);
    push_voxel(32'h0000_0005, 1'b1);
    push_voxel(32'h0000_0000, 1'b1);
    push_voxel(32'h0000_0003, 1'b0);
    push_voxel(32'h0000_0000, 1'b1);
    push_voxel(32'h0000_0007, 1'b1);
    settle();

    // largest threshold selects nothing
    write_threshold(32'h7fff_ffff);
    push_voxel(32'h7fff_ffff, 1'b0);
    push_voxel(32'h8000_0000, 1'b0);
    push_voxel(32'h1234_5678, 1'b1);
    settle();

    // smallest threshold selects all but the minimum
    write_threshold(32'h8000_0000);
    push_voxel(32'h8000_0000, 1'b0);
    push_voxel(32'h8000_0001, 1'b0);
    push_voxel(32'h0000_0000, 1'b0);
    push_voxel(32'h7fff_ffff, 1'b1);
    push_voxel(32'h8000_0000, 1'b1);

    run_phase($urandom, 0, 0, 80, 1'b0);
    run_phase(32'h8000_0000, 52, 0, 80, 1'b0);
    run_phase(32'h0000_0000, 0, 52, 80, 1'b0);
    run_phase(32'h7fff_ffff, 22, 22, 30, 1'b0);
    // receiver holds off while voxels keep coming, so the block backs up
    run_phase($urandom, 0, 0, 80, 1'b1);
    run_phase(32'hffff_ffff, 22, 22, 80, 1'b0);
    settle();

    if (errors == 0) begin
      $display("threshold_sparse_run_encoder_unit verification clean");
    end else begin
      $display("threshold_sparse_run_encoder_unit verification failed");
    end
    $finish;
  end

endmodule
